// File: hdl/cwuq_pkg.sv
// ============================================================================
// cwuq_pkg
// Shared types, codes and helpers of the credit window update queue.
// ============================================================================
package cwuq_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_WORD_WIDTH  = 32;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int CREDIT_W = 16;
    localparam int LIMIT_W  = 5;
    localparam int MARK_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam int CNT_OUT_W = 5;
    localparam int SQUASH_W = 16;

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 3'd0,
        OP_POST  = 3'd1,
        OP_ACK   = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4,
        OP_SEND  = 3'd5,
        OP_CLEAR = 3'd6
    } t_op;

    // Run state as shown on the response.
    typedef enum logic [1:0] {
        RUN_IDLE = 2'd0,
        RUN_EXEC = 2'd1,
        RUN_DEAD = 2'd2
    } t_run;

    // Request handling phase.
    typedef enum logic {
        PH_ACCEPT = 1'b0,
        PH_EXEC   = 1'b1
    } t_phase;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIPELINE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK     = 3'd4;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT   = 5'd4;
    localparam logic [LIMIT_W-1:0] RST_ACK_THRESHOLD = 5'd1;

    // Watermark clamped to one below the ack threshold; a zero threshold
    // leaves the mark as it is.
    function automatic logic [LIMIT_W-1:0] eff_mark(input logic [LIMIT_W-1:0] thr,
                                                    input logic [MARK_W-1:0] mark);
        logic [LIMIT_W-1:0] m;
        logic [LIMIT_W-1:0] cap;
        m   = {1'b0, mark};
        cap = thr - 1'b1;
        if (thr == '0) begin
            return m;
        end
        return (m < cap) ? m : cap;
    endfunction

endpackage

// File: hdl/cwuq_req_if.sv
// ============================================================================
// cwuq_req_if
// Request channel of the credit window update queue.
// ============================================================================
interface cwuq_req_if #(
    parameter int WORD_WIDTH = cwuq_pkg::DEF_WORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [cwuq_pkg::OP_W-1:0]     operation;
    logic [WORD_WIDTH-1:0]         update_word;
    logic                          has_changes;
    logic                          is_finish;
    logic                          may_drop;
    logic                          force_push;
    logic [cwuq_pkg::CREDIT_W-1:0] credit_amount;

    modport source (
        output valid, operation, update_word, has_changes, is_finish,
               may_drop, force_push, credit_amount,
        input  ready
    );

    modport sink (
        input  valid, operation, update_word, has_changes, is_finish,
               may_drop, force_push, credit_amount,
        output ready
    );
endinterface

// File: hdl/cwuq_rsp_if.sv
// ============================================================================
// cwuq_rsp_if
// Response channel of the credit window update queue.
// ============================================================================
interface cwuq_rsp_if #(
    parameter int WORD_WIDTH = cwuq_pkg::DEF_WORD_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic                           room_left;
    logic                           out_valid;
    logic [WORD_WIDTH-1:0]          out_word;
    logic                           out_finish;
    logic                           low_event;
    logic                           high_event;
    logic [cwuq_pkg::CNT_OUT_W-1:0] entry_count;
    logic [cwuq_pkg::CREDIT_W-1:0]  credit_level;
    logic [cwuq_pkg::CNT_OUT_W-1:0] peak_count;
    logic [cwuq_pkg::SQUASH_W-1:0]  squash_total;
    logic [1:0]                     run_state;

    modport source (
        output valid, room_left, out_valid, out_word, out_finish, low_event,
               high_event, entry_count, credit_level, peak_count,
               squash_total, run_state,
        input  ready
    );

    modport sink (
        input  valid, room_left, out_valid, out_word, out_finish, low_event,
               high_event, entry_count, credit_level, peak_count,
               squash_total, run_state,
        output ready
    );
endinterface

// File: hdl/credit_window_update_queue_top.sv
// ============================================================================
// credit_window_update_queue_top
// Subscription update queue with credit window flow control.
// ============================================================================
// Usage:
// Requests arrive on i_req (valid/ready); each request carries one operation:
// init, post, ack, start, stop, send slot or clear statistics. Every request
// produces exactly one response on o_rsp with the post result, the emitted
// entry of a send slot, the watermark pulses and the queue statistics.
// The queued entries live in a synchronous memory of QUEUE_DEPTH words. The
// head entry is read at the edge that accepts a request; in the following
// cycle the request is executed against that data, the tail entry is written
// and the response register is loaded. A new request is taken only after the
// previous one has executed, since the head is read from a synchronous memory.
// If the receiver stalls, the response is held and no further request is
// accepted until the response has been taken, but a request is accepted in
// the same cycle that the waiting response leaves.
// Reset empties the queue, clears credit and statistics, puts the block in
// the idle run state and loads the configuration defaults. The memory needs
// no clearing pass: an entry's data is used only after it has been written.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata
// while no request is in flight: a rule for the user, unchecked by the block.
// ============================================================================
module credit_window_update_queue_top #(
    parameter int QUEUE_DEPTH = cwuq_pkg::DEF_QUEUE_DEPTH,
    parameter int WORD_WIDTH  = cwuq_pkg::DEF_WORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cwuq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cwuq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    cwuq_req_if.sink                          i_req,
    cwuq_rsp_if.source                        o_rsp
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = CNT_W + cwuq_pkg::LIMIT_W;
    localparam int CR_W  = cwuq_pkg::CREDIT_W;

    // Configuration registers.
    logic                            r_pipe;
    logic [cwuq_pkg::LIMIT_W-1:0]    r_limit;
    logic [cwuq_pkg::LIMIT_W-1:0]    r_thr;
    logic [cwuq_pkg::MARK_W-1:0]     r_low_mark;
    logic [cwuq_pkg::MARK_W-1:0]     r_high_mark;

    // Queue state.
    cwuq_pkg::t_phase                r_phase, n_phase;
    logic [PTR_W-1:0]                r_head, n_head;
    logic [PTR_W-1:0]                r_tail, n_tail;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CR_W-1:0]                 r_credit, n_credit;
    cwuq_pkg::t_run                  r_run, n_run;
    logic                            r_fin, n_fin;
    logic [CNT_W-1:0]                r_peak, n_peak;
    logic [cwuq_pkg::SQUASH_W-1:0]   r_squash, n_squash;

    // Entry memory: finish bit above the data word.
    logic [WORD_WIDTH:0]             r_mem [QUEUE_DEPTH];
    logic [WORD_WIDTH-1:0]           r_rd_word;
    logic                            r_rd_fin;
    logic                            mem_we;
    logic [PTR_W-1:0]                mem_addr;
    logic [WORD_WIDTH:0]             mem_wdata;

    // Latched request.
    cwuq_pkg::t_op                   r_op;
    logic [WORD_WIDTH-1:0]           r_req_word;
    logic                            r_req_chg;
    logic                            r_req_fin;
    logic                            r_req_drop;
    logic                            r_req_force;
    logic [CR_W-1:0]                 r_req_amt;

    // Response register.
    logic                            r_ovalid;
    logic                            r_o_room;
    logic                            r_o_emit;
    logic [WORD_WIDTH-1:0]           r_o_word;
    logic                            r_o_fin;
    logic                            r_o_low;
    logic                            r_o_high;
    logic [CNT_W-1:0]                r_o_count;
    logic [CR_W-1:0]                 r_o_credit;
    logic [CNT_W-1:0]                r_o_peak;
    logic [cwuq_pkg::SQUASH_W-1:0]   r_o_squash;
    cwuq_pkg::t_run                  r_o_run;

    // Next response values.
    logic                            n_room;
    logic                            n_emit;
    logic [WORD_WIDTH-1:0]           n_word;
    logic                            n_ofin;
    logic                            n_low;
    logic                            n_high;
    logic [CNT_W-1:0]                rpt_peak;
    logic [cwuq_pkg::SQUASH_W-1:0]   rpt_squash;

    // Helpers.
    logic                            req_acc;
    logic                            exec;
    logic [PTR_W-1:0]                tail_next;
    logic [PTR_W-1:0]                tail_prev;
    logic [PTR_W-1:0]                head_next;
    logic                            below_limit;
    logic                            full;
    logic                            append_ok;
    logic [CR_W:0]                   credit_sum;
    logic [cwuq_pkg::LIMIT_W-1:0]    eff_low;
    logic [cwuq_pkg::LIMIT_W-1:0]    eff_high;
    logic [CMP_W-1:0]                cnt_ext;
    logic [CMP_W-1:0]                peak_ext;

    assign i_req.ready = (r_phase == cwuq_pkg::PH_ACCEPT) && (!r_ovalid || o_rsp.ready);
    assign req_acc     = i_req.valid && i_req.ready;
    assign exec        = (r_phase == cwuq_pkg::PH_EXEC);

    assign tail_next = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? PTR_W'(QUEUE_DEPTH - 1) : r_tail - 1'b1;
    assign head_next = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign below_limit = {{cwuq_pkg::LIMIT_W{1'b0}}, r_count} < {{CNT_W{1'b0}}, r_limit};
    assign full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign append_ok   = below_limit || r_req_force || r_req_fin;
    assign credit_sum  = {1'b0, r_credit} + {1'b0, r_req_amt};
    assign eff_low     = cwuq_pkg::eff_mark(r_thr, r_low_mark);
    assign eff_high    = cwuq_pkg::eff_mark(r_thr, r_high_mark);

    // Clear statistics reports the values held before clearing.
    assign rpt_peak   = (r_op == cwuq_pkg::OP_CLEAR) ? r_peak : n_peak;
    assign rpt_squash = (r_op == cwuq_pkg::OP_CLEAR) ? r_squash : n_squash;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe      <= 1'b0;
            r_limit     <= cwuq_pkg::RST_QUEUE_LIMIT;
            r_thr       <= cwuq_pkg::RST_ACK_THRESHOLD;
            r_low_mark  <= '0;
            r_high_mark <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cwuq_pkg::CFG_PIPELINE_MODE: r_pipe      <= i_cfg_wdata[0];
                cwuq_pkg::CFG_QUEUE_LIMIT:   r_limit     <= i_cfg_wdata;
                cwuq_pkg::CFG_ACK_THRESHOLD: r_thr       <= i_cfg_wdata;
                cwuq_pkg::CFG_LOW_MARK:      r_low_mark  <= i_cfg_wdata[cwuq_pkg::MARK_W-1:0];
                cwuq_pkg::CFG_HIGH_MARK:     r_high_mark <= i_cfg_wdata[cwuq_pkg::MARK_W-1:0];
                default: ;
            endcase
        end
    end

    // Entry memory. The head is read as a request is accepted; writes come
    // only in the execute phase that follows, so a read never meets a write.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (req_acc) begin
            {r_rd_fin, r_rd_word} <= r_mem[r_head];
        end
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_op        <= cwuq_pkg::t_op'(i_req.operation);
            r_req_word  <= i_req.update_word;
            r_req_chg   <= i_req.has_changes;
            r_req_fin   <= i_req.is_finish;
            r_req_drop  <= i_req.may_drop;
            r_req_force <= i_req.force_push;
            r_req_amt   <= i_req.credit_amount;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cwuq_pkg::PH_ACCEPT;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_credit <= '0;
            r_run    <= cwuq_pkg::RUN_IDLE;
            r_fin    <= 1'b0;
            r_peak   <= '0;
            r_squash <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_credit <= n_credit;
            r_run    <= n_run;
            r_fin    <= n_fin;
            r_peak   <= n_peak;
            r_squash <= n_squash;
            if (exec) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_o_room   <= n_room;
            r_o_emit   <= n_emit;
            r_o_word   <= n_word;
            r_o_fin    <= n_ofin;
            r_o_low    <= n_low;
            r_o_high   <= n_high;
            r_o_count  <= n_count;
            r_o_credit <= n_credit;
            r_o_peak   <= rpt_peak;
            r_o_squash <= rpt_squash;
            r_o_run    <= n_run;
        end
    end

    // Next state: the latched request is executed in the cycle after it
    // is accepted, with the head entry available from the memory.
    always_comb begin
        n_phase   = r_phase;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_credit  = r_credit;
        n_run     = r_run;
        n_fin     = r_fin;
        n_peak    = r_peak;
        n_squash  = r_squash;
        mem_we    = 1'b0;
        mem_addr  = r_tail;
        mem_wdata = {r_req_fin, r_req_word};
        n_room    = 1'b0;
        n_emit    = 1'b0;
        n_word    = '0;
        n_ofin    = 1'b0;
        n_low     = 1'b0;
        n_high    = 1'b0;

        unique case (r_phase)
            cwuq_pkg::PH_ACCEPT: begin
                if (req_acc) begin
                    n_phase = cwuq_pkg::PH_EXEC;
                end
            end
            cwuq_pkg::PH_EXEC: begin
                n_phase = cwuq_pkg::PH_ACCEPT;
                unique case (r_op)
                    cwuq_pkg::OP_INIT: begin
                        n_head   = '0;
                        n_tail   = '0;
                        n_count  = '0;
                        n_fin    = 1'b0;
                        n_run    = cwuq_pkg::RUN_IDLE;
                        n_peak   = '0;
                        n_squash = '0;
                        n_credit = r_req_amt;
                    end
                    cwuq_pkg::OP_POST: begin
                        if (!r_fin) begin
                            if (r_req_chg || r_req_fin) begin
                                if (append_ok) begin
                                    mem_we = 1'b1;
                                    if (full) begin
                                        // Storage is full: the tail entry is replaced.
                                        mem_addr = tail_prev;
                                        if (r_squash != '1) begin
                                            n_squash = r_squash + 1'b1;
                                        end
                                    end else begin
                                        mem_addr = r_tail;
                                        n_tail   = tail_next;
                                        n_count  = r_count + 1'b1;
                                        if (r_peak < n_count) begin
                                            n_peak = n_count;
                                        end
                                    end
                                    n_fin = r_req_fin;
                                end else if (!r_req_drop && r_count != '0) begin
                                    mem_we    = 1'b1;
                                    mem_addr  = tail_prev;
                                    mem_wdata = {1'b0, r_req_word};
                                    if (r_squash != '1) begin
                                        n_squash = r_squash + 1'b1;
                                    end
                                end
                            end
                            n_room = ({{cwuq_pkg::LIMIT_W{1'b0}}, n_count}
                                      < {{CNT_W{1'b0}}, r_limit}) && !n_fin;
                        end
                    end
                    cwuq_pkg::OP_ACK: begin
                        if (r_run != cwuq_pkg::RUN_DEAD && r_pipe) begin
                            n_credit = credit_sum[CR_W] ? '1 : credit_sum[CR_W-1:0];
                            n_high   = (n_credit > {{(CR_W - cwuq_pkg::LIMIT_W){1'b0}}, eff_high})
                                       && !r_fin;
                        end
                    end
                    cwuq_pkg::OP_START: begin
                        if (r_run != cwuq_pkg::RUN_DEAD) begin
                            n_run = cwuq_pkg::RUN_EXEC;
                        end
                    end
                    cwuq_pkg::OP_STOP: begin
                        if (r_run != cwuq_pkg::RUN_DEAD) begin
                            n_run = cwuq_pkg::RUN_IDLE;
                        end
                    end
                    cwuq_pkg::OP_SEND: begin
                        if (r_run == cwuq_pkg::RUN_EXEC && r_count != '0 &&
                            (!r_pipe || r_credit != '0 || r_fin)) begin
                            n_emit  = 1'b1;
                            n_word  = r_rd_word;
                            n_ofin  = r_rd_fin;
                            n_head  = head_next;
                            n_count = r_count - 1'b1;
                            if (r_rd_fin) begin
                                n_run = cwuq_pkg::RUN_DEAD;
                            end else if (r_pipe && r_credit != '0) begin
                                n_credit = r_credit - 1'b1;
                                n_low    = n_credit
                                           <= {{(CR_W - cwuq_pkg::LIMIT_W){1'b0}}, eff_low};
                            end
                        end
                    end
                    cwuq_pkg::OP_CLEAR: begin
                        n_peak   = '0;
                        n_squash = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Counts leave on fixed 5-bit fields.
    assign cnt_ext  = {{cwuq_pkg::LIMIT_W{1'b0}}, r_o_count};
    assign peak_ext = {{cwuq_pkg::LIMIT_W{1'b0}}, r_o_peak};

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.room_left    = r_o_room;
    assign o_rsp.out_valid    = r_o_emit;
    assign o_rsp.out_word     = r_o_word;
    assign o_rsp.out_finish   = r_o_fin;
    assign o_rsp.low_event    = r_o_low;
    assign o_rsp.high_event   = r_o_high;
    assign o_rsp.entry_count  = cnt_ext[cwuq_pkg::CNT_OUT_W-1:0];
    assign o_rsp.credit_level = r_o_credit;
    assign o_rsp.peak_count   = peak_ext[cwuq_pkg::CNT_OUT_W-1:0];
    assign o_rsp.squash_total = r_o_squash;
    assign o_rsp.run_state    = r_o_run;

endmodule

// File: hdl/cwuq_check.sv
// ============================================================================
// cwuq_check
// Port-level checks of the credit window update queue.
// ============================================================================
module cwuq_check #(
    parameter int WORD_WIDTH = cwuq_pkg::DEF_WORD_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic                  i_room_left,
    input logic                  i_out_valid,
    input logic                  i_out_finish,
    input logic [WORD_WIDTH-1:0] i_out_word,
    input logic [1:0]            i_run_state
);

    // Every accepted request gets its response.
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |-> ##2 i_rsp_valid)
        else $error("response missing after accepted request");

    // A request is executed in the cycle after acceptance, so no back-to-back accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is executing");

    // Sending the finish marker leaves the block dead.
    a_finish_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_out_valid && i_out_finish)
            |-> (i_run_state == cwuq_pkg::RUN_DEAD))
        else $error("finish marker sent but block not dead");

    // A post that reports room left never emits an entry.
    a_post_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_room_left) |-> !i_out_valid)
        else $error("post response carries an emitted entry");

    // A stalled response keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_out_word)))
        else $error("stalled response changed");

endmodule

bind credit_window_update_queue_top cwuq_check #(.WORD_WIDTH(WORD_WIDTH)) u_cwuq_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_room_left  (o_rsp.room_left),
    .i_out_valid  (o_rsp.out_valid),
    .i_out_finish (o_rsp.out_finish),
    .i_out_word   (o_rsp.out_word),
    .i_run_state  (o_rsp.run_state)
);
